FILE: design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find/replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int WIN_DEPTH       = 8;
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int SLOT_W          = $clog2(WIN_DEPTH);
  localparam int COUNT_W         = $clog2(WIN_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } reg_index_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic              shift;
  } cell_ctrl_t;

endpackage

FILE: design/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window position: holds a pending byte, compares it with its pattern
// byte, and takes its neighbor's byte when the row shifts toward the head.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] next_byte,
  input  logic [7:0] pattern_byte,
  output logic [7:0] data,
  output logic       eq
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_byte;
    end else if (shift) begin
      data <= next_byte;
    end
  end

  assign eq = (data == pattern_byte);

endmodule

FILE: design/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window
// Row of window cells. Cell 0 holds the oldest pending byte; a shift moves
// every byte one cell toward the head.
// ----------------------------------------------------------------------------
module sfr_window (
  input  logic                             clk,
  input  sfr_pkg::cell_ctrl_t              ctrl,
  input  logic [7:0]                       in_byte,
  input  logic [8*sfr_pkg::WIN_DEPTH-1:0]  pattern_bytes,
  output logic [7:0]                       head_byte,
  output logic [sfr_pkg::WIN_DEPTH-1:0]    eq
);

  logic [7:0] data [sfr_pkg::WIN_DEPTH];

  for (genvar i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin : g_cell
    logic [7:0] next_byte;

    if (i == sfr_pkg::WIN_DEPTH - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_mid
      assign next_byte = data[i+1];
    end

    sfr_cell u_cell (
      .clk          (clk),
      .load         (ctrl.load && (ctrl.slot == sfr_pkg::SLOT_W'(i))),
      .shift        (ctrl.shift),
      .load_byte    (in_byte),
      .next_byte    (next_byte),
      .pattern_byte (pattern_bytes[8*i +: 8]),
      .data         (data[i]),
      .eq           (eq[i])
    );
  end

  assign head_byte = data[0];

endmodule

FILE: design/streaming_find_replace.sv
// ----------------------------------------------------------------------------
// streaming_find_replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement string, and closes each text with a count marker.
//
// Usage: text items enter on in_byte/in_last under in_valid/in_stall; result
// items leave on out_byte/byte_valid/match_total/out_last under
// out_valid/out_stall. Pattern and replacement are set over the APB port at
// byte addresses 0, 8, 16 and 24 while the block is idle.
// Timing: an item is taken in one cycle and judged against the pattern in
// the next. The output register is then filled once a cycle while the output
// is not stalled, and the cell row shifts one position for each pending byte
// sent out. in_stall stays high until all results of the item are in the
// output register.
// Reset empties the window, clears the match count and the output valid flag,
// and clears the configuration (pattern length resets to 1). A stalled result
// holds the output register and the block waits with it; nothing is dropped.
// ----------------------------------------------------------------------------
module streaming_find_replace (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [31:0] match_total,
  output logic        out_last
);

  localparam int CW = sfr_pkg::COUNT_W;
  localparam int SW = sfr_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN,
    S_REPL,
    S_FLUSH
  } state_t;

  state_t      state;
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic [CW-1:0] count;
  logic [CW-1:0] drain_n;
  logic [SW-1:0] rep_idx;
  logic          last_q;
  logic [31:0]   match_counter;

  logic [CW-1:0] plen;
  logic [CW-1:0] rlen;
  logic [sfr_pkg::WIN_DEPTH-1:0] eq;
  logic [sfr_pkg::WIN_DEPTH-1:0] used;
  logic          hit;
  logic [7:0]    head_byte;
  logic          slot_free;
  logic          accept;
  logic          cfg_write;
  state_t        after;
  sfr_pkg::cell_ctrl_t ctrl;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (sfr_pkg::reg_index_t'(paddr[4:3]))
        sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= pwdata[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sfr_pkg::reg_index_t'(paddr[4:3]))
      sfr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes;
      sfr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length};
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length};
      default:                         prdata = '0;
    endcase
  end

  // effective lengths
  always_comb begin
    if (pattern_length == 4'd0) begin
      plen = CW'(1);
    end else if (pattern_length > 4'(sfr_pkg::MAX_PATTERN)) begin
      plen = CW'(sfr_pkg::MAX_PATTERN);
    end else begin
      plen = CW'(pattern_length);
    end
    if (replacement_length > 4'(sfr_pkg::MAX_REPLACEMENT)) begin
      rlen = CW'(sfr_pkg::MAX_REPLACEMENT);
    end else begin
      rlen = CW'(replacement_length);
    end
  end

  always_comb begin
    for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin
      used[i] = (CW'(i) < plen);
    end
  end

  assign hit = &(eq | ~used);

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign after     = last_q ? S_FLUSH : S_IDLE;

  always_comb begin
    ctrl.load  = accept;
    ctrl.slot  = count[SW-1:0];
    ctrl.shift = slot_free &&
                 ((state == S_DRAIN) || ((state == S_FLUSH) && (count != '0)));
  end

  sfr_window u_window (
    .clk           (clk),
    .ctrl          (ctrl),
    .in_byte       (in_byte),
    .pattern_bytes (pattern_bytes),
    .head_byte     (head_byte),
    .eq            (eq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      match_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // draining, replacing and flushing emit an item whenever the slot is free
      if (slot_free) begin
        out_valid <= state inside {S_DRAIN, S_REPL, S_FLUSH};
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count  <= count + CW'(1);
            last_q <= in_last;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (count > plen) begin
            drain_n <= count - plen + CW'(1);
            state   <= S_DRAIN;
          end else if (count == plen) begin
            if (hit) begin
              count   <= '0;
              rep_idx <= '0;
              if (match_counter != 32'hFFFF_FFFF) begin
                match_counter <= match_counter + 32'd1;
              end
              state <= (rlen == '0) ? after : S_REPL;
            end else begin
              drain_n <= CW'(1);
              state   <= S_DRAIN;
            end
          end else begin
            state <= after;
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            out_byte    <= head_byte;
            byte_valid  <= 1'b1;
            match_total <= '0;
            out_last    <= 1'b0;
            count       <= count - CW'(1);
            drain_n     <= drain_n - CW'(1);
            if (drain_n == CW'(1)) begin
              state <= after;
            end
          end
        end
        S_REPL: begin
          if (slot_free) begin
            out_byte    <= replacement_bytes[8*rep_idx +: 8];
            byte_valid  <= 1'b1;
            match_total <= '0;
            out_last    <= 1'b0;
            rep_idx     <= rep_idx + SW'(1);
            if ({1'b0, rep_idx} == rlen - CW'(1)) begin
              state <= after;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            if (count != '0) begin
              out_byte    <= head_byte;
              byte_valid  <= 1'b1;
              match_total <= '0;
              out_last    <= 1'b0;
              count       <= count - CW'(1);
            end else begin
              out_byte      <= '0;
              byte_valid    <= 1'b0;
              match_total   <= match_counter;
              out_last      <= 1'b1;
              match_counter <= '0;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a new byte always finds a free cell
  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count < CW'(sfr_pkg::WIN_DEPTH)))
    else $error("window full at accept");

  // the window is never left full between items
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count < plen || count < CW'(sfr_pkg::WIN_DEPTH)))
    else $error("window overfull while idle");

  // an item always lands in the window before it is judged
  a_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (count != '0))
    else $error("evaluation with empty window");

  // end marker carries no text byte
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (!byte_valid && out_byte == 8'h00))
    else $error("malformed end marker");

  // a drain never runs past the bytes held
  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (drain_n != '0 && drain_n <= count))
    else $error("drain beyond window");

endmodule

FILE: test/streaming_find_replace_tb.sv
// ----------------------------------------------------------------------------
// streaming_find_replace_tb
// Self-checking bench for the streaming find/replace block. Text items are
// sent with random gaps while the result side stalls at random. A scoreboard
// predicts every output byte and end marker from the accepted items and the
// pattern/replacement registers written over APB between phases. Directed
// texts cover deletion, full-length patterns and replacements, clamped
// lengths and a pattern length lowered with bytes still pending. Random
// phases then mix pattern copies, broken prefixes and noise.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [7:0]  ch;
  logic        is_text;
  logic [31:0] total;
  logic        is_end;
} out_item_t;

class replace_tracker;
  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  win [sfr_pkg::WIN_DEPTH];
  int unsigned win_cnt;
  logic [31:0] hits;
  out_item_t   expected_out[$];
  int          errors;
  int          shown;

  function new();
    pat_bytes = '0;
    pat_len   = 4'd1;
    rep_bytes = '0;
    rep_len   = 4'd0;
    win_cnt   = 0;
    hits      = '0;
    errors    = 0;
    shown     = 0;
  endfunction

  function void set_reg(sfr_pkg::reg_index_t idx, logic [63:0] v);
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES:      pat_bytes = v;
      sfr_pkg::REG_PATTERN_LENGTH:     pat_len   = v[3:0];
      sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes = v;
      sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len   = v[3:0];
      default: ;
    endcase
  endfunction

  function int unsigned eff_pat_len();
    int unsigned p;
    p = pat_len;
    if (p == 0) p = 1;
    if (p > sfr_pkg::MAX_PATTERN) p = sfr_pkg::MAX_PATTERN;
    return p;
  endfunction

  function void emit(logic [7:0] ch, logic is_text, logic [31:0] total, logic is_end);
    out_item_t o;
    o.ch      = ch;
    o.is_text = is_text;
    o.total   = total;
    o.is_end  = is_end;
    expected_out.push_back(o);
  endfunction

  // oldest k window bytes go out, the rest move down
  function void drain(int unsigned k);
    int unsigned i;
    if (k > win_cnt) k = win_cnt;
    for (i = 0; i < k; i++) emit(win[i], 1'b1, '0, 1'b0);
    for (i = k; i < win_cnt; i++) win[i-k] = win[i];
    win_cnt -= k;
  endfunction

  function void take_byte(logic [7:0] b, logic last);
    int unsigned plen;
    int unsigned rlen;
    int unsigned i;
    bit          hit;
    plen = eff_pat_len();
    rlen = rep_len;
    if (rlen > sfr_pkg::MAX_REPLACEMENT) rlen = sfr_pkg::MAX_REPLACEMENT;
    if (win_cnt >= sfr_pkg::WIN_DEPTH) win_cnt = sfr_pkg::WIN_DEPTH - 1;
    win[win_cnt] = b;
    win_cnt++;
    if (win_cnt > plen) begin
      drain(win_cnt - (plen - 1));
    end else if (win_cnt == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) emit(rep_bytes[8*i +: 8], 1'b1, '0, 1'b0);
        win_cnt = 0;
        if (hits != 32'hFFFF_FFFF) hits++;
      end else begin
        drain(1);
      end
    end
    if (last) begin
      drain(win_cnt);
      emit(8'h00, 1'b0, hits, 1'b1);
      hits    = '0;
      win_cnt = 0;
    end
  endfunction

  function void check_out(out_item_t got);
    out_item_t want;
    if (expected_out.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected item: byte %h text %b total %0d end %b",
                 got.ch, got.is_text, got.total, got.is_end);
      end
      return;
    end
    want = expected_out.pop_front();
    if (got !== want) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display({"mismatch: expected byte %h text %b total %0d end %b, ",
                  "got byte %h text %b total %0d end %b"},
                 want.ch, want.is_text, want.total, want.is_end,
                 got.ch, got.is_text, got.total, got.is_end);
      end
    end
  endfunction
endclass

module streaming_find_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [31:0] match_total;
  logic        out_last;

  replace_tracker tracker = new();
  bit             steady;
  int             items_sent;
  logic [7:0]     text_q[$];

  streaming_find_replace i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .match_total(match_total),
    .out_last   (out_last)
  );

  always #4 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(sfr_pkg::reg_index_t idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [7:0] b, logic l);
    int unsigned n;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b, l);
    items_sent++;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text(bit close);
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], close && (i == text_q.size() - 1));
    end
    text_q.delete();
  endtask

  // block idle: every result out, plus room for items that emit nothing
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_out.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_out(out_item_t'({out_byte, byte_valid, match_total, out_last}));
    end
  end

  initial begin
    int unsigned n;
    int unsigned m;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      m = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (m) @(posedge clk);
    end
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [63:0] pat;
    logic [63:0] word;
    logic [7:0]  alph [4];
    int unsigned nsym;
    int unsigned plen;
    int unsigned ntext;
    int unsigned tlen;
    int unsigned r;
    int unsigned k;
    int unsigned t;
    int unsigned i;
    bit          first;
    bit          close;

    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    in_last    <= 1'b0;
    steady     = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte pattern deleted, byte extremes
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    text_q = '{8'h00, 8'hFF, 8'h00};
    send_text(1'b1);
    settle();

    // full-length pattern and replacement
    pat = 64'h80FF_7F01_00FE_55AA;
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd8);
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
    text_q.push_back(8'h11);
    for (i = 0; i < 8; i++) text_q.push_back(pat[8*i +: 8]);
    text_q.push_back(8'h00);
    send_text(1'b1);
    settle();

    // zero pattern length acts as one, oversize replacement clamps
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    text_q = '{8'hAA, 8'hAA};
    send_text(1'b1);
    settle();

    // oversize pattern clamps; then length lowered with seven bytes pending
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
    for (i = 0; i < 7; i++) text_q.push_back(pat[8*i +: 8]);
    send_text(1'b0);
    settle();
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
    send_item(8'h42, 1'b1);
    settle();

    first = 1'b1;
    while (items_sent < 430) begin
      steady = ($urandom_range(0, 3) == 0);
      nsym = $urandom_range(2, 4);
      for (i = 0; i < 4; i++) alph[i] = 8'($urandom_range(0, 255));

      r = $urandom_range(0, 9);
      if (r == 0) plen = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      else plen = $urandom_range(1, 8);
      word = {$urandom, $urandom};
      for (i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
        word[8*i +: 8] = alph[$urandom_range(0, nsym - 1)];
      end
      if (first || $urandom_range(0, 3) != 0) write_reg(sfr_pkg::REG_PATTERN_BYTES, word);
      if (first || $urandom_range(0, 3) != 0) begin
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
      end
      if (first || $urandom_range(0, 3) != 0) begin
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      end
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      if (first || $urandom_range(0, 3) != 0) begin
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'(r));
      end
      first = 1'b0;

      pat  = tracker.pat_bytes;
      plen = tracker.eff_pat_len();
      ntext = $urandom_range(1, 3);
      for (t = 0; t < ntext; t++) begin
        tlen = $urandom_range(1, 40);
        while (text_q.size() < tlen) begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            for (i = 0; i < plen; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (r < 6) begin
            k = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
            for (i = 0; i < k; i++) text_q.push_back(pat[8*i +: 8]);
            text_q.push_back(alph[$urandom_range(0, nsym - 1)]);
          end else if (r < 9) begin
            text_q.push_back(alph[$urandom_range(0, nsym - 1)]);
          end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        close = (t != ntext - 1) || ($urandom_range(0, 4) != 0);
        send_text(close);
      end
      settle();
    end

    in_valid <= 1'b0;
    while (tracker.expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sfr_pkg.sv
design/sfr_cell.sv
design/sfr_window.sv
design/streaming_find_replace.sv
test/streaming_find_replace_tb.sv
